FILE: rtl/core/hse_pkg.sv
// hse_pkg: shared constants and command codes for the hash set engine
// no dependencies; imported by every module of the engine

package hse_pkg;

    localparam int CFG_W            = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam int KEY_BITS         = 32;
    localparam int CMD_W            = 2;

    localparam int DEF_MAX_BUCKETS  = 64;
    localparam int DEF_BUCKET_SLOTS = 8;
    localparam int QUEUE_DEPTH      = 2;

    localparam int S_TDATA_W        = 40;
    localparam int M_TDATA_W        = 8;

    localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CONTAINS = 2'd2;

endpackage

FILE: rtl/core/hash_set_engine_unit.sv
// hash_set_engine_unit: top level of the hash set engine
// instantiates hse_front, hse_queue and hse_back; depends on hse_pkg
//
//  channel   direction  handshake          payload
//  s_        in         s_tvalid/s_tready  s_tdata: command, key
//  m_        out        m_tvalid/m_tready  m_tdata: success, bucket_full
//  cfg_      in         cfg_wr_en          cfg_wr_data: bucket_count
//
// front takes a new item only once the last one's bucket is in the queue, bound by the bit-serial modulo
// back works on one item at a time, overlapped with the front
// after reset the back clears every row of the occupancy memory; s_tready stays low
// a waiting result stalls the back; the front keeps taking items until the queue is full

module hash_set_engine_unit import hse_pkg::*; #(
    parameter int MAX_BUCKETS  = DEF_MAX_BUCKETS,
    parameter int BUCKET_SLOTS = DEF_BUCKET_SLOTS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,      // command[1:0], key[33:2], zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,      // success[0], bucket_full[1], zero pad
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data
);

    localparam int BUCKET_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int JOB_W    = BUCKET_W + KEY_BITS + CMD_W;

    logic [CFG_W-1:0]    bucket_count_reg;
    logic [CFG_W-1:0]    eff_div;
    logic                clear_busy;

    logic                push_valid, push_ready;
    logic [CMD_W-1:0]    push_cmd;
    logic [KEY_BITS-1:0] push_key;
    logic [BUCKET_W-1:0] push_bucket;
    logic                pop_valid, pop_ready;
    logic [JOB_W-1:0]    pop_data;
    logic                res_success, res_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bucket_count_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            bucket_count_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        eff_div = bucket_count_reg;
        if (bucket_count_reg == '0) begin
            eff_div = CFG_W'(1);
        end else if (int'(bucket_count_reg) > MAX_BUCKETS) begin
            eff_div = CFG_W'(MAX_BUCKETS);
        end
    end

    hse_front #(
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .divisor    (eff_div),
        .hold       (clear_busy),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tdata[CMD_W-1:0]),
        .in_key     (s_tdata[CMD_W+KEY_BITS-1:CMD_W]),
        .out_valid  (push_valid),
        .out_ready  (push_ready),
        .out_cmd    (push_cmd),
        .out_key    (push_key),
        .out_bucket (push_bucket)
    );

    hse_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_bucket, push_key, push_cmd}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    hse_back #(
        .MAX_BUCKETS  (MAX_BUCKETS),
        .BUCKET_SLOTS (BUCKET_SLOTS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (pop_valid),
        .job_ready   (pop_ready),
        .job_cmd     (pop_data[CMD_W-1:0]),
        .job_key     (pop_data[CMD_W+KEY_BITS-1:CMD_W]),
        .job_bucket  (pop_data[JOB_W-1:CMD_W+KEY_BITS]),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_success (res_success),
        .res_full    (res_full),
        .clear_busy  (clear_busy)
    );

    assign m_tdata = {{(M_TDATA_W - 2){1'b0}}, res_full, res_success};

    // assertions
    a_no_accept_while_clearing: assert property (
        @(posedge aclk) disable iff (!aresetn) clear_busy |-> !s_tready
    ) else $error("item accepted during occupancy clear");

    a_bucket_in_range: assert property (
        @(posedge aclk) disable iff (!aresetn)
        push_valid |-> ({{CFG_W{1'b0}}, push_bucket}
                        < {{BUCKET_W{1'b0}}, eff_div})
    ) else $error("bucket not below bucket count");

    a_full_excludes_success: assert property (
        @(posedge aclk) disable iff (!aresetn) m_tvalid |-> !(res_success && res_full)
    ) else $error("full flag together with success");

    a_result_needs_job: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (pop_valid && pop_ready) |=> !(pop_ready)
    ) else $error("back took a new item before finishing the last");

endmodule

FILE: rtl/core/hse_front.sv
// hse_front: accepts items and works out the bucket by restoring division
// one quotient bit a cycle; depends on hse_pkg

module hse_front import hse_pkg::*; #(
    parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
    localparam int BUCKET_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [CFG_W-1:0]    divisor,
    input  logic                hold,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    in_cmd,
    input  logic [KEY_BITS-1:0] in_key,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CMD_W-1:0]    out_cmd,
    output logic [KEY_BITS-1:0] out_key,
    output logic [BUCKET_W-1:0] out_bucket
);

    localparam int CNT_W = $clog2(KEY_BITS);

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    front_state_t        state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CFG_W-1:0]    rem_reg, rem_next;
    logic [CFG_W-1:0]    div_reg, div_next;
    logic [KEY_BITS-1:0] shift_reg, shift_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [CFG_W:0]      trial;

    assign in_ready   = (state_reg == F_IDLE) && !hold;
    assign out_valid  = (state_reg == F_PUSH);
    assign out_cmd    = cmd_reg;
    assign out_key    = key_reg;
    assign out_bucket = BUCKET_W'(rem_reg);

    assign trial = {rem_reg, shift_reg[KEY_BITS-1]};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        shift_next = shift_reg;
        key_next   = key_reg;
        cmd_next   = cmd_reg;
        case (state_reg)
            F_IDLE: begin
                if (in_valid && in_ready) begin
                    key_next   = in_key;
                    cmd_next   = in_cmd;
                    shift_next = in_key;
                    div_next   = divisor;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = F_DIV;
                end
            end
            F_DIV: begin
                if (trial >= {1'b0, div_reg}) begin
                    rem_next = CFG_W'(trial - {1'b0, div_reg});
                end else begin
                    rem_next = trial[CFG_W-1:0];
                end
                shift_next = {shift_reg[KEY_BITS-2:0], 1'b0};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(KEY_BITS - 1)) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (out_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            div_reg   <= div_next;
            shift_reg <= shift_next;
            key_reg   <= key_next;
            cmd_reg   <= cmd_next;
        end
    end

endmodule

FILE: rtl/core/hse_queue.sv
// hse_queue: short first-in first-out queue between front and back
// generic width; depends on hse_pkg for the default depth

module hse_queue import hse_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/hse_back.sv
// hse_back: bucket slot scan, update and result register
// holds the key and occupancy memories; depends on hse_pkg

module hse_back import hse_pkg::*; #(
    parameter int MAX_BUCKETS  = DEF_MAX_BUCKETS,
    parameter int BUCKET_SLOTS = DEF_BUCKET_SLOTS,
    localparam int BUCKET_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    output logic                job_ready,
    input  logic [CMD_W-1:0]    job_cmd,
    input  logic [KEY_BITS-1:0] job_key,
    input  logic [BUCKET_W-1:0] job_bucket,
    output logic                res_valid,
    input  logic                res_ready,
    output logic                res_success,
    output logic                res_full,
    output logic                clear_busy
);

    localparam int SLOT_TOTAL = MAX_BUCKETS * BUCKET_SLOTS;
    localparam int ADDR_W     = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
    localparam int SLOT_W     = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_MASK,
        B_SCAN,
        B_DONE
    } back_state_t;

    logic [BUCKET_SLOTS-1:0] mask_mem [MAX_BUCKETS];
    logic [KEY_BITS-1:0]     key_mem  [SLOT_TOTAL];

    back_state_t             state_reg, state_next;
    logic [BUCKET_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [CMD_W-1:0]        cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]     key_reg, key_next;
    logic [BUCKET_W-1:0]     bucket_reg, bucket_next;
    logic [BUCKET_SLOTS-1:0] mask_reg, mask_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic                    hit_reg, hit_next;
    logic [SLOT_W-1:0]       hit_slot_reg, hit_slot_next;
    logic                    free_reg, free_next;
    logic [SLOT_W-1:0]       free_slot_reg, free_slot_next;
    logic                    res_valid_reg, res_valid_next;
    logic                    res_success_reg, res_success_next;
    logic                    res_full_reg, res_full_next;

    logic                    mask_we;
    logic [BUCKET_W-1:0]     mask_waddr;
    logic [BUCKET_SLOTS-1:0] mask_wdata;
    logic [BUCKET_SLOTS-1:0] mask_rdata;
    logic                    key_we;
    logic [ADDR_W-1:0]       key_waddr;
    logic [ADDR_W-1:0]       key_raddr;
    logic [KEY_BITS-1:0]     key_rdata;
    logic [ADDR_W-1:0]       base;
    logic [SLOT_W:0]         slot_inc;
    logic                    out_free;
    logic                    hit_now;

    assign base      = ADDR_W'(bucket_reg * BUCKET_SLOTS);
    assign slot_inc  = {1'b0, slot_reg} + 1'b1;
    assign out_free  = !res_valid_reg || res_ready;
    assign hit_now   = mask_reg[slot_reg] && (key_rdata == key_reg);

    assign job_ready   = (state_reg == B_IDLE);
    assign clear_busy  = (state_reg == B_CLEAR);
    assign res_valid   = res_valid_reg;
    assign res_success = res_success_reg;
    assign res_full    = res_full_reg;

    always_comb begin
        key_raddr = base + ADDR_W'(slot_inc);
        if (state_reg == B_MASK) begin
            key_raddr = base;
        end
    end

    always_comb begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        bucket_next      = bucket_reg;
        mask_next        = mask_reg;
        slot_next        = slot_reg;
        hit_next         = hit_reg;
        hit_slot_next    = hit_slot_reg;
        free_next        = free_reg;
        free_slot_next   = free_slot_reg;
        res_valid_next   = res_valid_reg && !res_ready;
        res_success_next = res_success_reg;
        res_full_next    = res_full_reg;
        mask_we          = 1'b0;
        mask_waddr       = bucket_reg;
        mask_wdata       = mask_reg;
        key_we           = 1'b0;
        key_waddr        = base + ADDR_W'(free_slot_reg);
        case (state_reg)
            B_CLEAR: begin
                mask_we      = 1'b1;
                mask_waddr   = clr_cnt_reg;
                mask_wdata   = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == BUCKET_W'(MAX_BUCKETS - 1)) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (job_valid) begin
                    cmd_next    = job_cmd;
                    key_next    = job_key;
                    bucket_next = job_bucket;
                    hit_next    = 1'b0;
                    free_next   = 1'b0;
                    state_next  = B_MASK;
                end
            end
            B_MASK: begin
                mask_next  = mask_rdata;
                slot_next  = '0;
                state_next = B_SCAN;
            end
            B_SCAN: begin
                if (hit_now) begin
                    hit_next      = 1'b1;
                    hit_slot_next = slot_reg;
                    state_next    = B_DONE;
                end else begin
                    if (!mask_reg[slot_reg] && !free_reg) begin
                        free_next      = 1'b1;
                        free_slot_next = slot_reg;
                    end
                    if (slot_reg == SLOT_W'(BUCKET_SLOTS - 1)) begin
                        state_next = B_DONE;
                    end else begin
                        slot_next = slot_inc[SLOT_W-1:0];
                    end
                end
            end
            B_DONE: begin
                if (out_free) begin
                    res_valid_next   = 1'b1;
                    res_success_next = 1'b0;
                    res_full_next    = 1'b0;
                    state_next       = B_IDLE;
                    case (cmd_reg)
                        CMD_ADD: begin
                            if (!hit_reg) begin
                                if (free_reg) begin
                                    key_we           = 1'b1;
                                    mask_we          = 1'b1;
                                    mask_wdata       = mask_reg
                                                     | (BUCKET_SLOTS'(1) << free_slot_reg);
                                    res_success_next = 1'b1;
                                end else begin
                                    res_full_next = 1'b1;
                                end
                            end
                        end
                        CMD_REMOVE: begin
                            if (hit_reg) begin
                                mask_we          = 1'b1;
                                mask_wdata       = mask_reg
                                                 & ~(BUCKET_SLOTS'(1) << hit_slot_reg);
                                res_success_next = 1'b1;
                            end
                        end
                        CMD_CONTAINS: begin
                            res_success_next = hit_reg;
                        end
                        default: begin
                            res_success_next = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_CLEAR;
            clr_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            res_valid_reg   <= res_valid_next;
            cmd_reg         <= cmd_next;
            key_reg         <= key_next;
            bucket_reg      <= bucket_next;
            mask_reg        <= mask_next;
            slot_reg        <= slot_next;
            hit_reg         <= hit_next;
            hit_slot_reg    <= hit_slot_next;
            free_reg        <= free_next;
            free_slot_reg   <= free_slot_next;
            res_success_reg <= res_success_next;
            res_full_reg    <= res_full_next;
        end
    end

    // occupancy memory, one row per bucket
    always_ff @(posedge aclk) begin
        if (mask_we) begin
            mask_mem[mask_waddr] <= mask_wdata;
        end
        mask_rdata <= mask_mem[job_bucket];
    end

    // key memory, one entry per slot
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_waddr] <= key_reg;
        end
        key_rdata <= key_mem[key_raddr];
    end

endmodule
